// ----- hw/rtl/mt_pkg.sv -----
// shared constants, payload types and control structs for the mt19937 generator
`default_nettype none
package mt_pkg;

    localparam int unsigned WORDS      = 624;
    localparam int unsigned ADDR_W     = 10;

    localparam logic [ADDR_W-1:0] WORDS_IDX  = 10'd624;
    localparam logic [ADDR_W-1:0] LAST_IDX   = 10'd623;
    localparam logic [ADDR_W-1:0] SHIFT_OFS  = 10'd397;
    localparam logic [ADDR_W-1:0] UNSEEDED   = 10'd625;

    localparam logic [31:0] TWIST_XOR    = 32'h9908b0df;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc60000;
    localparam logic [31:0] SEED_MUL     = 32'd69069;
    localparam logic [31:0] DEFAULT_SEED = 32'd4357;

    localparam logic FUNC_DRAW = 1'b0;
    localparam logic FUNC_SEED = 1'b1;

    typedef struct packed {
        logic        func;
        logic [31:0] seed;
    } req_word_t;

    typedef struct packed {
        logic [31:0] value;
    } rsp_word_t;

    typedef struct packed {
        logic seed_load;
        logic seed_dflt;
        logic seed_step;
        logic tw_start;
        logic tw_rd;
        logic tw_wr;
        logic draw_rd;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic unseeded;
        logic at_end;
        logic cnt_last;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mt_stream_if.sv -----
// valid/ready channel carrying one word of a given payload type
`default_nettype none
interface mt_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/mersenne_twister_prng_top.sv -----
// top level of the mt19937 generator: request and result channels
`default_nettype none
// MT19937 generator with the original multiplicative seeding. A request word
// with func set reseeds: after the accept, each of the 624 words of the state
// memory is written in turn through its single write port. A draw reads the
// memory, then tempers the word into the output register. The first draw
// after a seed, and every 624th draw from then on, first regenerates the
// state: each word is read (two read ports) and, since the memory read is
// registered, written back in a separate write state; the fresh first word is
// then read once more. A draw before any seed also seeds with 4357 first. A
// result waiting in the output register does not block seeding; a further
// draw waits for it.
module mersenne_twister_prng_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mt_stream_if.sink   req,
    mt_stream_if.source rsp
);

    mt_pkg::cmd_t      cmd;
    mt_pkg::status_t   status;
    mt_pkg::req_word_t req_word;
    mt_pkg::rsp_word_t rsp_word;
    logic              out_valid;
    logic [31:0]       value;

    assign req_word = req.payload;

    mt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_func  (req_word.func),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    mt_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .seed      (req_word.seed),
        .out_ready (rsp.ready),
        .out_valid (out_valid),
        .value     (value),
        .status    (status)
    );

    assign rsp_word.value = value;
    assign rsp.valid      = out_valid;
    assign rsp.payload    = rsp_word;

endmodule
`default_nettype wire

// ----- hw/rtl/mt_dpath.sv -----
// state memory, seeding multiplier, twist and tempering datapath
`default_nettype none
module mt_dpath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mt_pkg::cmd_t    cmd,
    input  wire logic [31:0]     seed,
    input  wire logic            out_ready,
    output logic                 out_valid,
    output logic [31:0]          value,
    output mt_pkg::status_t      status
);

    logic [31:0] mem [0:mt_pkg::WORDS-1];

    logic [31:0]               rd_a_reg;
    logic [31:0]               rd_b_reg;
    logic [31:0]               cur_reg;
    logic [31:0]               cur_next;
    logic [31:0]               value_reg;
    logic [mt_pkg::ADDR_W-1:0] cnt_reg;
    logic [mt_pkg::ADDR_W-1:0] cnt_next;
    logic [mt_pkg::ADDR_W-1:0] idx_reg;
    logic [mt_pkg::ADDR_W-1:0] idx_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;

    logic [mt_pkg::ADDR_W-1:0] nxt_addr;
    logic [mt_pkg::ADDR_W-1:0] far_sum;
    logic [mt_pkg::ADDR_W-1:0] far_addr;
    logic [mt_pkg::ADDR_W-1:0] ra_a;
    logic                      re_a;
    logic                      re_b;
    logic                      we;
    logic [31:0]               wd;
    logic [31:0]               y;
    logic [31:0]               twisted;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] t;
        t = w ^ (w >> 11);
        t = t ^ ((t << 7) & mt_pkg::TEMPER_B);
        t = t ^ ((t << 15) & mt_pkg::TEMPER_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

    always_comb
    begin
        nxt_addr = (cnt_reg == mt_pkg::LAST_IDX) ? '0 : cnt_reg + 1'b1;
        far_sum  = cnt_reg + mt_pkg::SHIFT_OFS;
        far_addr = (far_sum >= mt_pkg::WORDS_IDX) ? far_sum - mt_pkg::WORDS_IDX : far_sum;

        y       = {cur_reg[31], rd_a_reg[30:0]};
        twisted = rd_b_reg ^ (y >> 1) ^ (y[0] ? mt_pkg::TWIST_XOR : 32'd0);

        re_a = cmd.tw_start | cmd.tw_rd | cmd.draw_rd;
        re_b = cmd.tw_rd;
        if (cmd.tw_rd)
        begin
            ra_a = nxt_addr;
        end
        else if (cmd.draw_rd)
        begin
            ra_a = idx_reg;
        end
        else
        begin
            ra_a = '0;
        end

        we = cmd.seed_step | cmd.tw_wr;
        wd = cmd.seed_step ? cur_reg : twisted;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[cnt_reg] <= wd;
        end
        if (re_a)
        begin
            rd_a_reg <= mem[ra_a];
        end
        if (re_b)
        begin
            rd_b_reg <= mem[far_addr];
        end
    end

    always_comb
    begin
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg & ~out_ready;

        if (cmd.seed_load)
        begin
            cur_next = cmd.seed_dflt ? mt_pkg::DEFAULT_SEED : seed;
            cnt_next = '0;
        end
        if (cmd.seed_step)
        begin
            cur_next = 32'(cur_reg * mt_pkg::SEED_MUL);
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == mt_pkg::LAST_IDX)
            begin
                idx_next = mt_pkg::WORDS_IDX;
            end
        end
        if (cmd.tw_start)
        begin
            cnt_next = '0;
        end
        if (cmd.tw_rd)
        begin
            cur_next = rd_a_reg;
        end
        if (cmd.tw_wr)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == mt_pkg::LAST_IDX)
            begin
                idx_next = '0;
            end
        end
        if (cmd.out_load)
        begin
            idx_next       = idx_reg + 1'b1;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (cmd.out_load)
        begin
            value_reg <= temper(rd_a_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            idx_reg       <= mt_pkg::UNSEEDED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign value           = value_reg;
    assign status.unseeded = (idx_reg == mt_pkg::UNSEEDED);
    assign status.at_end   = (idx_reg >= mt_pkg::WORDS_IDX) && (idx_reg != mt_pkg::UNSEEDED);
    assign status.cnt_last = (cnt_reg == mt_pkg::LAST_IDX);
    assign status.out_free = ~out_valid_reg | out_ready;

endmodule
`default_nettype wire

// ----- hw/rtl/mt_ctrl.sv -----
// sequencer for seeding, twisting and drawing
`default_nettype none
module mt_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_func,
    output logic                 in_ready,
    input  wire mt_pkg::status_t status,
    output mt_pkg::cmd_t         cmd
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_SEED    = 7'b0000010,
        ST_TW_PRE  = 7'b0000100,
        ST_TW_RD   = 7'b0001000,
        ST_TW_WR   = 7'b0010000,
        ST_DRAW_RD = 7'b0100000,
        ST_DRAW_LD = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   pend_reg;
    logic   pend_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid & in_ready;

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        cmd        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_func == mt_pkg::FUNC_SEED)
                    begin
                        cmd.seed_load = 1'b1;
                        pend_next     = 1'b0;
                        state_next    = ST_SEED;
                    end
                    else if (status.unseeded)
                    begin
                        cmd.seed_load = 1'b1;
                        cmd.seed_dflt = 1'b1;
                        pend_next     = 1'b1;
                        state_next    = ST_SEED;
                    end
                    else if (status.at_end)
                    begin
                        cmd.tw_start = 1'b1;
                        state_next   = ST_TW_RD;
                    end
                    else
                    begin
                        cmd.draw_rd = 1'b1;
                        state_next  = ST_DRAW_LD;
                    end
                end
            end
            ST_SEED:
            begin
                cmd.seed_step = 1'b1;
                if (status.cnt_last)
                begin
                    state_next = pend_reg ? ST_TW_PRE : ST_IDLE;
                    pend_next  = 1'b0;
                end
            end
            ST_TW_PRE:
            begin
                cmd.tw_start = 1'b1;
                state_next   = ST_TW_RD;
            end
            ST_TW_RD:
            begin
                cmd.tw_rd  = 1'b1;
                state_next = ST_TW_WR;
            end
            ST_TW_WR:
            begin
                cmd.tw_wr  = 1'b1;
                state_next = status.cnt_last ? ST_DRAW_RD : ST_TW_RD;
            end
            ST_DRAW_RD:
            begin
                cmd.draw_rd = 1'b1;
                state_next  = ST_DRAW_LD;
            end
            ST_DRAW_LD:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

endmodule
`default_nettype wire

// ----- tb/sv/tb_mersenne_twister_prng_top.sv -----
// self-checking bench for the mt19937 generator: seeded and drawn words against a predictor
module tb_mersenne_twister_prng_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] HI_MASK     = 32'h80000000;
    localparam logic [31:0] LO_MASK     = 32'h7fffffff;
    localparam int          QUIET_LIMIT = 20000;
    localparam int          DRAIN       = 2000;
    localparam int          ITEM_TOTAL  = 1150;

    class draw_checker;
        bit [31:0]   words [0:mt_pkg::WORDS-1];
        bit [9:0]    pos;
        bit [31:0]   pending_values [$];
        int          mismatches;
        int          strays;

        function new();
            for (int i = 0; i < mt_pkg::WORDS; i++)
                words[i] = '0;
            pos = mt_pkg::UNSEEDED;
            mismatches = 0;
            strays = 0;
        endfunction

        function void fill_from(bit [31:0] s);
            words[0] = s;
            for (int i = 1; i < mt_pkg::WORDS; i++)
                words[i] = words[i-1] * mt_pkg::SEED_MUL;
            pos = mt_pkg::WORDS_IDX;
        endfunction

        function void regenerate();
            int unsigned nxt;
            int unsigned far_idx;
            bit [31:0]   y;
            for (int unsigned k = 0; k < mt_pkg::WORDS; k++)
            begin
                nxt = (k + 1 < mt_pkg::WORDS) ? k + 1 : 0;
                far_idx = k + mt_pkg::SHIFT_OFS;
                if (far_idx >= mt_pkg::WORDS)
                    far_idx -= mt_pkg::WORDS;
                y = (words[k] & HI_MASK) | (words[nxt] & LO_MASK);
                words[k] = words[far_idx] ^ (y >> 1) ^ (y[0] ? mt_pkg::TWIST_XOR : 32'h0);
            end
            pos = '0;
        endfunction

        function bit [31:0] temper(bit [31:0] v);
            bit [31:0] y;
            y = v;
            y ^= y >> 11;
            y ^= (y << 7) & mt_pkg::TEMPER_B;
            y ^= (y << 15) & mt_pkg::TEMPER_C;
            y ^= y >> 18;
            return y;
        endfunction

        function void note_request(logic f, logic [31:0] s);
            if (f == mt_pkg::FUNC_SEED)
            begin
                fill_from(s);
                return;
            end
            if (pos >= mt_pkg::WORDS_IDX)
            begin
                if (pos == mt_pkg::UNSEEDED)
                    fill_from(mt_pkg::DEFAULT_SEED);
                regenerate();
            end
            pending_values.push_back(temper(words[pos]));
            pos++;
        endfunction

        function void check_value(logic [31:0] v);
            bit [31:0] want;
            if (pending_values.size() == 0)
            begin
                if (mismatches + strays < 10)
                    $display("unexpected value %08h with no draw pending", v);
                strays++;
                return;
            end
            want = pending_values.pop_front();
            if (v !== want)
            begin
                if (mismatches + strays < 10)
                    $display("value mismatch: expected %08h, got %08h", want, v);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_values.size();
        endfunction

        function int failures();
            return mismatches + strays + pending_values.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    mt_stream_if #(.payload_t(mt_pkg::req_word_t)) req_ch ();
    mt_stream_if #(.payload_t(mt_pkg::rsp_word_t)) rsp_ch ();

    mersenne_twister_prng_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    draw_checker board;
    int          sent_words = 0;
    int          quiet_cycles = 0;
    bit          no_idle = 1'b0;
    int          stall_left = 0;
    int          calm_left = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 60);
    endfunction

    task automatic send_word(input logic f, input logic [31:0] s);
        int unsigned       gap;
        mt_pkg::req_word_t w;
        gap = no_idle ? 0 : pick_gap();
        w.func = f;
        w.seed = s;
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.payload <= w;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        board.note_request(f, s);
        sent_words++;
    endtask

    task automatic draw_word();
        send_word(mt_pkg::FUNC_DRAW, $urandom);
    endtask

    task automatic seed_word(input logic [31:0] s);
        send_word(mt_pkg::FUNC_SEED, s);
    endtask

    // result side: random stalls with occasional long calm stretches
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 199) == 0)
                    calm_left = $urandom_range(100, 400);
                else if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            board.check_value(rsp_ch.payload.value);
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned run_len;
        int unsigned r;
        board = new();
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // draws before any seed fall back to the default seed
        send_word(mt_pkg::FUNC_DRAW, 32'h0);
        send_word(mt_pkg::FUNC_DRAW, 32'hffffffff);
        draw_word();
        // zero seed gives an all-zero state
        seed_word(32'h0);
        draw_word();
        draw_word();
        seed_word(32'hffffffff);
        draw_word();
        draw_word();
        seed_word(32'h1);
        draw_word();
        // back-to-back reseeds, the later one wins
        seed_word(32'h80000000);
        seed_word(32'h7fffffff);
        draw_word();
        draw_word();
        seed_word(mt_pkg::DEFAULT_SEED);
        draw_word();

        // one long run crossing the second regeneration
        no_idle = 1'b0;
        seed_word($urandom);
        run_len = $urandom_range(630, 700);
        for (int unsigned i = 0; i < run_len; i++)
        begin
            if (i % 50 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            draw_word();
        end

        while (sent_words < ITEM_TOTAL)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 8)
                seed_word(32'h0);
            else if (r < 16)
                seed_word(32'hffffffff);
            else if (r < 85)
                seed_word($urandom);
            run_len = $urandom_range(1, 24);
            for (int unsigned i = 0; i < run_len; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    seed_word($urandom);
                else
                    draw_word();
            end
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (board.failures() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
